// ===== rtl/vpt_pkg.sv =====
// shared types, constants and saturating add for the vertex perspective transform
// no dependencies
`default_nettype none

package vpt_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;

  // saturation value, also the overflow marker
  localparam logic [31:0] MIN_Q = 32'h8000_0000;

  // quotient bits produced by the restoring divider, one per stage
  localparam int DIV_STEPS = 33;
  // divider latency: operand stage, one stage per step, result stage
  localparam int DIV_LAT = DIV_STEPS + 2;
  // stages from accept to the last multiplier stage
  localparam int PIPE_DEPTH = DIV_LAT + 5;

  // item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  // one fixed point result with its overflow flag
  typedef struct packed {
    logic        ov;
    logic [31:0] val;
  } qres_t;

  // one lane: the three vertex products of a column and its row-3 entry
  typedef struct packed {
    qres_t [2:0] prod;
    logic [31:0] m3;
  } lane_out_t;

  // input item
  typedef struct packed {
    logic               kind;
    logic [3:0]         entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_inv_depth;
    logic               overflow;
  } out_item_t;

  // saturating 32-bit signed add
  function automatic qres_t qadd(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    qres_t r;
    s = {a[31], a} + {b[31], b};
    r.ov = (s[32] != s[31]);
    r.val = r.ov ? MIN_Q : s[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vertex_perspective_transform.sv =====
// top level of the vertex perspective transform: matrix store, lanes, merge,
// dividers and output stage; depends on vpt_pkg, vpt_lane, vpt_qmul, vpt_div
`default_nettype none

// Takes one item per cycle while in_stall_o is low. A load item writes one
// Q16.16 matrix entry at once and gives no result; a vertex item gives one
// result after the lanes, merge stage, dividers, back multipliers and output
// register. Four column lanes form the vertex products, a merge stage sums w
// and the depth term, and two restoring dividers, running side by side, form
// 1/w and w over depth; their depth sets the latency. Stall on the output
// freezes the pipeline only when its last stage holds a vertex, so bubbles
// still close up behind a waiting result. Reset clears the matrix store.
module vertex_perspective_transform (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire vpt_pkg::in_item_t   in_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output vpt_pkg::out_item_t       out_o
);

  localparam int NSTG = vpt_pkg::PIPE_DEPTH;
  localparam int DL   = vpt_pkg::DIV_LAT;

  typedef struct packed {
    logic [1:0][2:0][31:0] pc;
    logic [1:0][31:0]      m3c;
    logic                  ov;
    logic                  wz;
  } side_t;

  typedef struct packed {
    vpt_pkg::qres_t oz;
    logic           ov;
    logic           wz;
  } back_t;

  // flow control
  logic en;
  logic out_load;
  logic accept;
  logic out_valid_q;
  logic [NSTG:1] vld_q;

  assign out_load = !out_valid_q || !out_stall_i;
  assign en = out_load || !vld_q[NSTG];
  assign in_stall_o = !en;
  assign accept = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-1:1], accept && (in_i.kind == vpt_pkg::KIND_VERTEX)};
    end
  end

  // matrix store
  logic [31:0] mat_q [16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        mat_q[i] <= '0;
      end
    end else if (accept && (in_i.kind == vpt_pkg::KIND_LOAD)) begin
      mat_q[in_i.entry_index] <= in_i.entry_value;
    end
  end

  // column lanes
  vpt_pkg::lane_out_t lane [4];

  for (genvar c = 0; c < 4; c++) begin : g_lane
    vpt_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .m0_i  (mat_q[c]),
      .m1_i  (mat_q[4 + c]),
      .m2_i  (mat_q[8 + c]),
      .m3_i  (mat_q[12 + c]),
      .vx_i  (in_i.vec_x),
      .vy_i  (in_i.vec_y),
      .vz_i  (in_i.vec_z),
      .lane_o(lane[c])
    );
  end

  // merge: w from column 3, depth sum from column 2
  vpt_pkg::qres_t a1, a2, wsum, b1, b2, zsum;
  logic  ov_prod;
  side_t side_d;
  side_t side_q;
  logic [31:0] w_q;
  logic [31:0] zd_q;

  always_comb begin
    a1 = vpt_pkg::qadd(lane[3].prod[2].val, lane[3].m3);
    a2 = vpt_pkg::qadd(lane[3].prod[1].val, a1.val);
    wsum = vpt_pkg::qadd(lane[3].prod[0].val, a2.val);
    b1 = vpt_pkg::qadd(lane[2].prod[0].val, lane[2].prod[1].val);
    b2 = vpt_pkg::qadd(lane[2].prod[2].val, lane[2].m3);
    zsum = vpt_pkg::qadd(b1.val, b2.val);
    ov_prod = 1'b0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 3; r++) begin
        ov_prod = ov_prod | lane[c].prod[r].ov;
      end
    end
    for (int c = 0; c < 2; c++) begin
      for (int r = 0; r < 3; r++) begin
        side_d.pc[c][r] = lane[c].prod[r].val;
      end
      side_d.m3c[c] = lane[c].m3;
    end
    side_d.ov = ov_prod | a1.ov | a2.ov | wsum.ov | b1.ov | b2.ov | zsum.ov;
    side_d.wz = (wsum.val == 32'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q <= side_d;
      w_q    <= wsum.val;
      zd_q   <= zsum.val;
    end
  end

  // reciprocal of w and inverse depth, in parallel
  vpt_pkg::qres_t iw;
  vpt_pkg::qres_t oz;

  vpt_div u_div_iw (
    .clk_i(clk_i),
    .en_i (en),
    .num_i(32'd1 << vpt_pkg::FRAC_BITS),
    .den_i(w_q),
    .res_o(iw)
  );

  vpt_div u_div_oz (
    .clk_i(clk_i),
    .en_i (en),
    .num_i(w_q),
    .den_i(zd_q),
    .res_o(oz)
  );

  // side data delayed to match the dividers
  side_t side_dl_q [1:DL];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_dl_q[1] <= side_q;
      for (int k = 2; k <= DL; k++) begin
        side_dl_q[k] <= side_dl_q[k-1];
      end
    end
  end

  // scale the x and y terms by 1/w
  vpt_pkg::qres_t tq [2][4];

  for (genvar c = 0; c < 2; c++) begin : g_back
    for (genvar r = 0; r < 4; r++) begin : g_term
      if (r < 3) begin : g_prod
        vpt_qmul u_mul (
          .clk_i(clk_i),
          .en_i (en),
          .a_i  (side_dl_q[DL].pc[c][r]),
          .b_i  (iw.val),
          .res_o(tq[c][r])
        );
      end else begin : g_const
        vpt_qmul u_mul (
          .clk_i(clk_i),
          .en_i (en),
          .a_i  (side_dl_q[DL].m3c[c]),
          .b_i  (iw.val),
          .res_o(tq[c][r])
        );
      end
    end
  end

  back_t bk_q1;
  back_t bk_q2;

  always_ff @(posedge clk_i) begin
    if (en) begin
      bk_q1.oz <= oz;
      bk_q1.ov <= side_dl_q[DL].ov | iw.ov;
      bk_q1.wz <= side_dl_q[DL].wz;
      bk_q2 <= bk_q1;
    end
  end

  // final sums and output register
  vpt_pkg::qres_t s01 [2];
  vpt_pkg::qres_t s23 [2];
  vpt_pkg::qres_t sum [2];
  logic ov_fin;
  vpt_pkg::out_item_t out_d;
  vpt_pkg::out_item_t out_q;

  always_comb begin
    ov_fin = bk_q2.ov | bk_q2.oz.ov;
    for (int c = 0; c < 2; c++) begin
      s01[c] = vpt_pkg::qadd(tq[c][0].val, tq[c][1].val);
      s23[c] = vpt_pkg::qadd(tq[c][2].val, tq[c][3].val);
      sum[c] = vpt_pkg::qadd(s01[c].val, s23[c].val);
      ov_fin = ov_fin | s01[c].ov | s23[c].ov | sum[c].ov;
      for (int r = 0; r < 4; r++) begin
        ov_fin = ov_fin | tq[c][r].ov;
      end
    end
    // zero w gives an all-zero result
    if (bk_q2.wz) begin
      out_d = '0;
    end else begin
      out_d.out_x = sum[0].val;
      out_d.out_y = sum[1].val;
      out_d.out_inv_depth = bk_q2.oz.val;
      out_d.overflow = ov_fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= vld_q[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o = out_q;

endmodule

`default_nettype wire

// ===== rtl/vpt_qmul.sv =====
// two-stage fixed point multiplier with round to nearest and saturation
// depends on vpt_pkg
`default_nettype none

module vpt_qmul (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [31:0]   a_i,
  input  wire logic [31:0]   b_i,
  output vpt_pkg::qres_t     res_o
);

  localparam int F = vpt_pkg::FRAC_BITS;

  logic signed [63:0] prod_q;
  logic [63:0]        mag;
  logic [63:0]        rnd;
  vpt_pkg::qres_t     res_d;
  vpt_pkg::qres_t     res_q;

  // raw product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= $signed(a_i) * $signed(b_i);
    end
  end

  // round the magnitude half away from zero, then apply sign and range check
  always_comb begin
    mag = prod_q[63] ? (~prod_q + 64'd1) : prod_q;
    rnd = (mag + (64'd1 << (F - 1))) >> F;
    if (prod_q[63]) begin
      res_d.ov = (rnd > 64'h0000_0000_8000_0000);
      res_d.val = ~rnd[31:0] + 32'd1;
    end else begin
      res_d.ov = (rnd > 64'h0000_0000_7FFF_FFFF);
      res_d.val = rnd[31:0];
    end
    if (res_d.ov) begin
      res_d.val = vpt_pkg::MIN_Q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== rtl/vpt_div.sv =====
// pipelined restoring divider for fixed point quotients, one quotient bit per stage
// depends on vpt_pkg
`default_nettype none

module vpt_div (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [31:0]   num_i,
  input  wire logic [31:0]   den_i,
  output vpt_pkg::qres_t     res_o
);

  localparam int F  = vpt_pkg::FRAC_BITS;
  localparam int NS = vpt_pkg::DIV_STEPS;
  localparam int NW = NS + F;

  // operand stage
  logic [31:0] mag_a_q;
  logic [31:0] mag_b_q;
  logic        neg_q;
  logic        bz_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_a_q <= num_i[31] ? (~num_i + 32'd1) : num_i;
      mag_b_q <= den_i[31] ? (~den_i + 32'd1) : den_i;
      neg_q   <= num_i[31] ^ den_i[31];
      bz_q    <= (den_i == 32'd0);
    end
  end

  // numerator scaled by two to the frac bits plus one
  logic [NW-1:0] nfull;
  assign nfull = {mag_a_q, {(F + 1){1'b0}}};

  logic [31:0]   rem_c [0:NS];
  logic [NS-1:0] quo_c [0:NS];
  logic [NS-1:0] nlo_c [0:NS];
  logic [31:0]   den_c [0:NS];
  logic          neg_c [0:NS];
  logic          big_c [0:NS];
  logic          bz_c  [0:NS];

  // initial partial remainder is the part above the quotient window;
  // if it already reaches the divisor the quotient cannot fit
  assign rem_c[0] = 32'(nfull[NW-1:NS]);
  assign quo_c[0] = '0;
  assign nlo_c[0] = nfull[NS-1:0];
  assign den_c[0] = mag_b_q;
  assign neg_c[0] = neg_q;
  assign big_c[0] = (32'(nfull[NW-1:NS]) >= mag_b_q);
  assign bz_c[0]  = bz_q;

  // one restoring step per stage
  for (genvar k = 1; k <= NS; k++) begin : g_step
    logic [32:0]   trial;
    logic          ge;
    logic [31:0]   rem_q;
    logic [NS-1:0] quo_q;
    logic [NS-1:0] nlo_q;
    logic [31:0]   den_q;
    logic          neg_q2;
    logic          big_q;
    logic          bz_q2;

    assign trial = {rem_c[k-1], nlo_c[k-1][NS-1]};
    assign ge = (trial >= {1'b0, den_c[k-1]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= ge ? 32'(trial - {1'b0, den_c[k-1]}) : trial[31:0];
        quo_q  <= {quo_c[k-1][NS-2:0], ge};
        nlo_q  <= {nlo_c[k-1][NS-2:0], 1'b0};
        den_q  <= den_c[k-1];
        neg_q2 <= neg_c[k-1];
        big_q  <= big_c[k-1];
        bz_q2  <= bz_c[k-1];
      end
    end

    assign rem_c[k] = rem_q;
    assign quo_c[k] = quo_q;
    assign nlo_c[k] = nlo_q;
    assign den_c[k] = den_q;
    assign neg_c[k] = neg_q2;
    assign big_c[k] = big_q;
    assign bz_c[k]  = bz_q2;
  end

  // round the half-unit quotient, apply sign and range check
  logic [NS:0]    q2p1;
  logic [NS-1:0]  rq;
  vpt_pkg::qres_t res_d;
  vpt_pkg::qres_t res_q;

  always_comb begin
    q2p1 = {1'b0, quo_c[NS]} + {{NS{1'b0}}, 1'b1};
    rq = q2p1[NS:1];
    if (neg_c[NS]) begin
      res_d.ov = (rq > NS'(33'h0_8000_0000));
      res_d.val = ~rq[31:0] + 32'd1;
    end else begin
      res_d.ov = (rq > NS'(33'h0_7FFF_FFFF));
      res_d.val = rq[31:0];
    end
    if (big_c[NS] || bz_c[NS]) begin
      res_d.ov = 1'b1;
    end
    if (res_d.ov) begin
      res_d.val = vpt_pkg::MIN_Q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== rtl/vpt_lane.sv =====
// one matrix column lane: products of the column entries with x, y and z
// depends on vpt_pkg and vpt_qmul
`default_nettype none

module vpt_lane (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [31:0]   m0_i,
  input  wire logic [31:0]   m1_i,
  input  wire logic [31:0]   m2_i,
  input  wire logic [31:0]   m3_i,
  input  wire logic [31:0]   vx_i,
  input  wire logic [31:0]   vy_i,
  input  wire logic [31:0]   vz_i,
  output vpt_pkg::lane_out_t lane_o
);

  vpt_pkg::qres_t p0, p1, p2;
  logic [31:0] m3_q1;
  logic [31:0] m3_q2;

  // row products
  vpt_qmul u_mul_x (.clk_i(clk_i), .en_i(en_i), .a_i(m0_i), .b_i(vx_i), .res_o(p0));
  vpt_qmul u_mul_y (.clk_i(clk_i), .en_i(en_i), .a_i(m1_i), .b_i(vy_i), .res_o(p1));
  vpt_qmul u_mul_z (.clk_i(clk_i), .en_i(en_i), .a_i(m2_i), .b_i(vz_i), .res_o(p2));

  // row-3 entry travels alongside the multipliers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m3_q1 <= m3_i;
      m3_q2 <= m3_q1;
    end
  end

  assign lane_o.prod = {p2, p1, p0};
  assign lane_o.m3 = m3_q2;

endmodule

`default_nettype wire

// ===== dv/vertex_perspective_transform_test.sv =====
// testbench for vertex_perspective_transform: random loads and vertices, checked
// against a fixed point projection predictor; depends on vpt_pkg and the rtl top
`default_nettype none

module vertex_perspective_transform_test;
  timeunit 1ns;
  timeprecision 1ps;

  // projection predictor and queue of projected vertices
  class projection_board;
    logic [31:0] mtx[16];
    vpt_pkg::out_item_t projected_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned loads;
    int unsigned vertices;
    int unsigned ovf_seen;

    function void clear();
      foreach (mtx[i]) mtx[i] = '0;
      mismatches = 0;
      checked = 0;
      loads = 0;
      vertices = 0;
      ovf_seen = 0;
    endfunction

    // pack magnitude with sign, saturate out of range
    function logic [31:0] fit(bit neg, logic [63:0] mag, ref bit ov);
      if (neg) begin
        if (mag > 64'h8000_0000) begin
          ov = 1;
          return vpt_pkg::MIN_Q;
        end
        return 32'(64'd0 - mag);
      end
      if (mag > 64'h7FFF_FFFF) begin
        ov = 1;
        return vpt_pkg::MIN_Q;
      end
      return mag[31:0];
    endfunction

    function logic [31:0] mul(logic [31:0] a, logic [31:0] b, ref bit ov);
      logic signed [63:0] p;
      logic [63:0] m;
      p = 64'(signed'(a)) * 64'(signed'(b));
      m = p < 0 ? 64'(-p) : 64'(p);
      m = (m + (64'd1 << (vpt_pkg::FRAC_BITS - 1))) >> vpt_pkg::FRAC_BITS;
      return fit(p < 0, m, ov);
    endfunction

    function logic [31:0] add(logic [31:0] a, logic [31:0] b, ref bit ov);
      logic signed [63:0] s;
      s = 64'(signed'(a)) + 64'(signed'(b));
      if (s > 64'sd2147483647 || s < -64'sd2147483648) begin
        ov = 1;
        return vpt_pkg::MIN_Q;
      end
      return s[31:0];
    endfunction

    function logic [31:0] div(logic [31:0] a, logic [31:0] b, ref bit ov);
      logic [63:0] ma, mb, q2;
      if (b == 0) begin
        ov = 1;
        return vpt_pkg::MIN_Q;
      end
      ma = a[31] ? 64'(-64'(signed'(a))) : 64'(a);
      mb = b[31] ? 64'(-64'(signed'(b))) : 64'(b);
      q2 = (ma << (vpt_pkg::FRAC_BITS + 1)) / mb;
      return fit(a[31] != b[31], (q2 + 1) >> 1, ov);
    endfunction

    function logic [31:0] m(int r, int c);
      return mtx[r * 4 + c];
    endfunction

    // one projected coordinate column
    function logic [31:0] column(int c, vpt_pkg::in_item_t it, logic [31:0] iw,
                                 ref bit ov);
      logic [31:0] t0, t1, t2, t3;
      t0 = mul(mul(m(0, c), it.vec_x, ov), iw, ov);
      t1 = mul(mul(m(1, c), it.vec_y, ov), iw, ov);
      t2 = mul(mul(m(2, c), it.vec_z, ov), iw, ov);
      t3 = mul(m(3, c), iw, ov);
      return add(add(t0, t1, ov), add(t2, t3, ov), ov);
    endfunction

    function void note_item(vpt_pkg::in_item_t it);
      logic [31:0] w, iw, zd;
      vpt_pkg::out_item_t r;
      bit ov;
      ov = 0;
      if (it.kind == vpt_pkg::KIND_LOAD) begin
        mtx[it.entry_index] = it.entry_value;
        loads++;
        return;
      end
      vertices++;
      w = add(mul(m(2, 3), it.vec_z, ov), m(3, 3), ov);
      w = add(mul(m(1, 3), it.vec_y, ov), w, ov);
      w = add(mul(m(0, 3), it.vec_x, ov), w, ov);
      if (w == 0) begin
        r = '0;
      end else begin
        iw = div(32'd1 << vpt_pkg::FRAC_BITS, w, ov);
        r.out_x = column(0, it, iw, ov);
        r.out_y = column(1, it, iw, ov);
        zd = add(add(mul(m(0, 2), it.vec_x, ov), mul(m(1, 2), it.vec_y, ov), ov),
                 add(mul(m(2, 2), it.vec_z, ov), m(3, 2), ov), ov);
        r.out_inv_depth = div(w, zd, ov);
        r.overflow = ov;
      end
      if (r.overflow) ovf_seen++;
      projected_q.push_back(r);
    endfunction

    function void check_result(vpt_pkg::out_item_t got);
      vpt_pkg::out_item_t exp_r;
      checked++;
      if (projected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = projected_q.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp x=%h y=%h d=%h ov=%b got x=%h y=%h d=%h ov=%b",
                   exp_r.out_x, exp_r.out_y, exp_r.out_inv_depth, exp_r.overflow,
                   got.out_x, got.out_y, got.out_inv_depth, got.overflow);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  vpt_pkg::in_item_t in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  vpt_pkg::out_item_t out_o;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  projection_board board = new();

  vertex_perspective_transform dut (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  // receiver: random stall, check at rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_o);
  end
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // drive one item, wait for acceptance; valid stays up for a following item
  task automatic send_item(vpt_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_i <= it;
    in_valid_i <= 1;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(it);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'h0;
      default: return 32'($signed($urandom_range(8 << vpt_pkg::FRAC_BITS))
                          - (4 << vpt_pkg::FRAC_BITS));
    endcase
  endfunction

  function automatic vpt_pkg::in_item_t load_item(int idx, logic [31:0] v);
    vpt_pkg::in_item_t it;
    it = '0;
    it.kind = vpt_pkg::KIND_LOAD;
    it.entry_index = 4'(idx);
    it.entry_value = v;
    it.vec_x = $urandom;
    it.vec_y = $urandom;
    it.vec_z = $urandom;
    return it;
  endfunction

  function automatic vpt_pkg::in_item_t vertex_item(logic [31:0] x, logic [31:0] y,
                                                   logic [31:0] z);
    vpt_pkg::in_item_t it;
    it.kind = vpt_pkg::KIND_VERTEX;
    it.entry_index = 4'($urandom);
    it.entry_value = $urandom;
    it.vec_x = x;
    it.vec_y = y;
    it.vec_z = z;
    return it;
  endfunction

  task automatic random_items(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        send_item(load_item($urandom_range(15), pick_value()));
      else
        send_item(vertex_item(pick_value(), pick_value(), pick_value()));
    end
  endtask

  initial begin
    board.clear();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // zero matrix gives zero w
    send_item(vertex_item(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    // identity-like matrix with w = 1 plus depth terms
    for (int d = 0; d < 4; d++) send_item(load_item(d * 5, 32'h0001_0000));
    send_item(vertex_item(32'h0002_0000, 32'hFFFF_0000, 32'h0003_0000));
    send_item(vertex_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
    // zero depth divisor
    send_item(load_item(10, 32'h0));
    send_item(load_item(14, 32'h0));
    send_item(vertex_item(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    // extreme entries, overflow paths
    send_item(load_item(15, 32'h8000_0000));
    send_item(load_item(0, 32'h7FFF_FFFF));
    send_item(vertex_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_item(load_item(15, 32'h0000_0001));
    send_item(vertex_item(32'h0, 32'h0, 32'h0));
    send_item(vertex_item(32'hFFFF_FFFF, 32'h0000_8000, 32'hFFFF_8000));

    send_idle_pct = 17;
    recv_idle_pct = 79;
    random_items(700);
    send_idle_pct = 79;
    recv_idle_pct = 17;
    random_items(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_items(800);
    in_valid_i <= 0;

    while (board.projected_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    $display("covered %0d loads, %0d vertices, %0d results checked, %0d with overflow",
             board.loads, board.vertices, board.checked, board.ovf_seen);
    if (board.mismatches == 0 && board.projected_q.size() == 0) begin
      $display("vertex_perspective_transform_test: done, clean");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("vertex_perspective_transform_test: done, errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("timeout");
    $display("vertex_perspective_transform_test: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
